// ===== src/x86d_pkg.sv =====
// Package for the 16-bit x86 decoder: constants, types and decode functions.
package x86d_pkg;

    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_MODRM  = 2'd1,
        PH_DISP   = 2'd2,
        PH_IMM    = 2'd3
    } phase_t;

    localparam logic [2:0] NO_PREFIX   = 3'd4;
    localparam logic [6:0] MN_PUSH     = 7'd8;
    localparam logic [6:0] MN_POP      = 7'd9;
    localparam logic [6:0] MN_PUSH_SEG = 7'd10;
    localparam logic [6:0] MN_POP_SEG  = 7'd11;
    localparam logic [6:0] MN_INC      = 7'd12;
    localparam logic [6:0] MN_DEC      = 7'd13;
    localparam logic [6:0] MN_JCC      = 7'd14;
    localparam logic [6:0] MN_MOV      = 7'd30;
    localparam logic [6:0] MN_MOV_SEG  = 7'd31;
    localparam logic [6:0] MN_STRING   = 7'd32;
    localparam logic [6:0] MN_TEST     = 7'd34;
    localparam logic [6:0] MN_RET      = 7'd38;
    localparam logic [6:0] MN_RETF     = 7'd39;
    localparam logic [6:0] MN_LES      = 7'd40;
    localparam logic [6:0] MN_LDS      = 7'd41;
    localparam logic [6:0] MN_INT      = 7'd42;
    localparam logic [6:0] MN_LOOPNZ   = 7'd50;
    localparam logic [6:0] MN_CALL     = 7'd54;
    localparam logic [6:0] MN_JMP      = 7'd55;
    localparam logic [6:0] MN_REPNE    = 7'd58;
    localparam logic [6:0] MN_GROUP3   = 7'd58;
    localparam logic [6:0] MN_FLAGS    = 7'd66;
    localparam logic [6:0] MN_UNKNOWN  = 7'd72;
    localparam logic [6:0] MN_RAW      = 7'd73;

    typedef struct packed {
        logic [6:0]  mnemonic;
        logic        operand_word;
        logic [1:0]  mod_field;
        logic [2:0]  reg_field;
        logic [2:0]  rm_field;
        logic        to_register;
        logic [2:0]  segment_prefix;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [15:0] branch_target;
        logic [3:0]  instr_length;
        logic        unknown;
    } record_t;

    function automatic logic [6:0] shift_mn(input logic [2:0] r);
        logic [6:0] m;
        case (r)
            3'd0: m = 7'd43;
            3'd1: m = 7'd44;
            3'd2: m = 7'd45;
            3'd3: m = 7'd46;
            3'd4: m = 7'd47;
            3'd5: m = 7'd48;
            3'd6: m = MN_UNKNOWN;
            default: m = 7'd49;
        endcase
        return m;
    endfunction

    function automatic logic [6:0] group5_mn(input logic [2:0] r);
        logic [6:0] m;
        case (r)
            3'd0: m = MN_INC;
            3'd1: m = MN_DEC;
            3'd2: m = MN_CALL;
            3'd3: m = 7'd56;
            3'd4: m = MN_JMP;
            3'd5: m = 7'd57;
            3'd6: m = MN_PUSH;
            default: m = MN_UNKNOWN;
        endcase
        return m;
    endfunction

    function automatic logic [15:0] sext8(input logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

    function automatic logic has_modrm(input logic [7:0] op);
        if (op < 8'h40) return (op[2:1] != 2'b11) && !op[2];
        return op == 8'h80 || op == 8'h81 || op == 8'h83 ||
               (op >= 8'h88 && op <= 8'h8C) || op == 8'h8E ||
               (op >= 8'hC4 && op <= 8'hC6) || (op >= 8'hD0 && op <= 8'hD3) ||
               op == 8'hF6 || op == 8'hF7 || op == 8'hFF;
    endfunction

    function automatic logic known_op(input logic [7:0] op);
        if (op < 8'h40) begin
            if (op[2:1] != 2'b11) return 1'b1;
            return ((op & 8'hE6) == 8'h06) && op != 8'h0F;
        end
        if (op < 8'h60 || (op >= 8'h70 && op <= 8'h7F)) return 1'b1;
        if (has_modrm(op)) return 1'b1;
        if (op >= 8'hA0 && op <= 8'hBF) return 1'b1;
        return op == 8'hC2 || op == 8'hC3 || op == 8'hCB || op == 8'hCD ||
               (op >= 8'hE0 && op <= 8'hE3) || op == 8'hE8 || op == 8'hE9 ||
               op == 8'hEB || op == 8'hF2 || op == 8'hF3 ||
               (op >= 8'hF8 && op <= 8'hFD);
    endfunction

    function automatic logic bad_second(input logic [7:0] op, input logic [7:0] m);
        if (op == 8'h8C || op == 8'h8E) return m[5];
        if (op == 8'hC4 || op == 8'hC5) return m[7:6] == 2'b11;
        if (op == 8'hC6) return m[5:3] != 3'd0;
        if (op >= 8'hD0 && op <= 8'hD3) return m[5:3] == 3'd6;
        if (op == 8'hF6 || op == 8'hF7) return m[5:3] == 3'd1;
        if (op == 8'hFF)
            return m[5:3] == 3'd7 || m[7:3] == 5'b11011 || m[7:3] == 5'b11101;
        return 1'b0;
    endfunction

    function automatic logic [1:0] disp_len(input logic [7:0] op, input logic [7:0] m);
        if (op >= 8'hA0 && op <= 8'hA3) return 2'd2;
        if (!has_modrm(op)) return 2'd0;
        case (m[7:6])
            2'd0: return (m[2:0] == 3'd6) ? 2'd2 : 2'd0;
            2'd1: return 2'd1;
            2'd2: return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] imm_len(input logic [7:0] op, input logic [7:0] m);
        if (op < 8'h40) begin
            if (op[2:0] == 3'd4) return 2'd1;
            if (op[2:0] == 3'd5) return 2'd2;
            return 2'd0;
        end
        if ((op >= 8'h70 && op <= 8'h7F) || op == 8'h80 || op == 8'h83 ||
            op == 8'hC6 || op == 8'hA8 || op == 8'hCD || op == 8'hEB ||
            (op >= 8'hE0 && op <= 8'hE3) || (op >= 8'hB0 && op <= 8'hB7))
            return 2'd1;
        if (op == 8'h81 || op == 8'hA9 || op == 8'hC2 || op == 8'hE8 ||
            op == 8'hE9 || (op >= 8'hB8 && op <= 8'hBF))
            return 2'd2;
        if (op == 8'hF6 || op == 8'hF7)
            return (m[5:3] == 3'd0) ? {1'b0, op[0]} + 2'd1 : 2'd0;
        return 2'd0;
    endfunction

endpackage

// ===== src/x86_16bit_instruction_decoder.sv =====
// Top level of the 16-bit x86 decoder: byte tracking state and result register.
//
//   channel | handshake               | payload
//   in      | in_valid / in_ready     | code_byte, block_first, block_ip
//   out     | out_valid / out_ready   | mnemonic .. unknown (one record)
//
// One code byte is taken per cycle; a record appears in the cycle after the byte
// that ends its instruction. The limit is the single result register: a new
// byte is taken whenever that register is empty or being emptied in the same
// cycle. Reset puts the decoder in its opcode phase with no prefix.
module x86_16bit_instruction_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  code_byte,
    input  logic        block_first,
    input  logic [15:0] block_ip,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  mnemonic,
    output logic        operand_word,
    output logic [1:0]  mod_field,
    output logic [2:0]  reg_field,
    output logic [2:0]  rm_field,
    output logic        to_register,
    output logic [2:0]  segment_prefix,
    output logic signed [15:0] displacement,
    output logic [15:0] immediate,
    output logic [15:0] branch_target,
    output logic [3:0]  instr_length,
    output logic        unknown
);
    x86d_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]  op_reg, op_next, m_reg, m_next;
    logic [1:0]  pend_reg, pend_next;
    logic [15:0] disp_reg, disp_next, imm_reg, imm_next, ip_reg, ip_next;
    logic [2:0]  pre_reg, pre_next;
    logic [3:0]  len_reg, len_next;
    logic        raw_reg, raw_next;
    logic        ov_reg;
    x86d_pkg::record_t rec_reg, rec_next, fin_rec, bad_rec;
    logic        bad_sel;
    logic        emit;
    logic        accept;

    // Values seen by the finish logic after this byte has been absorbed.
    logic [7:0]  f_op, f_m;
    logic [15:0] f_disp, f_imm;
    logic [2:0]  f_pre;
    logic [3:0]  f_len;
    logic [1:0]  dl, il;
    logic        start_imm_or_fin;

    assign in_ready = !ov_reg || out_ready;
    assign accept   = in_valid && in_ready;

    x86d_finish u_finish (
        .op(f_op), .m(f_m), .disp_acc(f_disp), .imm_acc(f_imm), .ip(ip_next),
        .prefix(f_pre), .len(f_len), .rec(fin_rec)
    );

    assign rec_next = bad_sel ? bad_rec : fin_rec;

    always_comb
    begin
        logic [2:0]  pre_in;
        logic [3:0]  len_in;
        logic        raw_in;
        x86d_pkg::phase_t ph_in;
        pre_in = pre_reg;
        len_in = len_reg;
        raw_in = raw_reg;
        ph_in  = phase_reg;
        ip_next = ip_reg;
        if (block_first) begin
            ph_in = x86d_pkg::PH_OPCODE;
            pre_in = x86d_pkg::NO_PREFIX;
            len_in = 4'd0;
            raw_in = 1'b0;
            ip_next = block_ip;
        end
        ip_next = ip_next + 16'd1;
        if (len_in != 4'd15) len_in = len_in + 4'd1;

        phase_next = ph_in;
        op_next = op_reg;
        m_next = m_reg;
        pend_next = block_first ? 2'd0 : pend_reg;
        disp_next = disp_reg;
        imm_next = imm_reg;
        pre_next = pre_in;
        len_next = len_in;
        raw_next = raw_in;
        emit = 1'b0;
        bad_sel = 1'b0;
        bad_rec = '0;
        f_op = op_reg;
        f_m = m_reg;
        f_disp = disp_reg;
        f_imm = imm_reg;
        f_pre = pre_in;
        f_len = len_in;
        start_imm_or_fin = 1'b0;
        dl = 2'd0;
        il = 2'd0;

        if (raw_in) begin
            emit = 1'b1;
            bad_sel = 1'b1;
            bad_rec.mnemonic = x86d_pkg::MN_RAW;
            bad_rec.segment_prefix = x86d_pkg::NO_PREFIX;
            bad_rec.immediate = {8'd0, code_byte};
            bad_rec.instr_length = 4'd1;
            bad_rec.unknown = 1'b1;
        end else begin
            unique case (ph_in)
                x86d_pkg::PH_MODRM:
                begin
                    m_next = code_byte;
                    f_m = code_byte;
                    if (x86d_pkg::bad_second(op_reg, code_byte)) begin
                        raw_next = 1'b1;
                        emit = 1'b1;
                        bad_sel = 1'b1;
                        bad_rec.mnemonic = x86d_pkg::MN_UNKNOWN;
                        bad_rec.segment_prefix = pre_in;
                        bad_rec.immediate = {code_byte, op_reg};
                        bad_rec.instr_length = len_in;
                        bad_rec.unknown = 1'b1;
                    end else begin
                        dl = x86d_pkg::disp_len(op_reg, code_byte);
                        if (dl != 2'd0) begin
                            phase_next = x86d_pkg::PH_DISP;
                            pend_next = dl;
                        end else begin
                            start_imm_or_fin = 1'b1;
                        end
                    end
                end
                x86d_pkg::PH_DISP:
                begin
                    dl = x86d_pkg::disp_len(op_reg, m_reg);
                    if (dl == 2'd2 && pend_reg == 2'd2)
                        disp_next = {disp_reg[15:8], code_byte};
                    else if (dl == 2'd2)
                        disp_next = {code_byte, disp_reg[7:0]};
                    else
                        disp_next = {8'd0, code_byte};
                    f_disp = disp_next;
                    pend_next = (pend_reg != 2'd0) ? pend_reg - 2'd1 : 2'd0;
                    if (pend_next == 2'd0) start_imm_or_fin = 1'b1;
                end
                x86d_pkg::PH_IMM:
                begin
                    il = x86d_pkg::imm_len(op_reg, m_reg);
                    if (il == 2'd2 && pend_reg == 2'd2)
                        imm_next = {imm_reg[15:8], code_byte};
                    else if (il == 2'd2)
                        imm_next = {code_byte, imm_reg[7:0]};
                    else
                        imm_next = {8'd0, code_byte};
                    f_imm = imm_next;
                    pend_next = (pend_reg != 2'd0) ? pend_reg - 2'd1 : 2'd0;
                    if (pend_next == 2'd0) emit = 1'b1;
                end
                default:
                begin
                    if ((code_byte & 8'hE7) == 8'h26) begin
                        pre_next = {1'b0, code_byte[4:3]};
                    end else begin
                        op_next = code_byte;
                        m_next = 8'd0;
                        disp_next = 16'd0;
                        imm_next = 16'd0;
                        f_op = code_byte;
                        f_m = 8'd0;
                        f_disp = 16'd0;
                        f_imm = 16'd0;
                        if (!x86d_pkg::known_op(code_byte)) begin
                            raw_next = 1'b1;
                            emit = 1'b1;
                            bad_sel = 1'b1;
                            bad_rec.mnemonic = x86d_pkg::MN_UNKNOWN;
                            bad_rec.segment_prefix = pre_in;
                            bad_rec.immediate = {8'd0, code_byte};
                            bad_rec.instr_length = len_in;
                            bad_rec.unknown = 1'b1;
                        end else if (x86d_pkg::has_modrm(code_byte)) begin
                            phase_next = x86d_pkg::PH_MODRM;
                        end else begin
                            dl = x86d_pkg::disp_len(code_byte, 8'd0);
                            if (dl != 2'd0) begin
                                phase_next = x86d_pkg::PH_DISP;
                                pend_next = dl;
                            end else begin
                                start_imm_or_fin = 1'b1;
                            end
                        end
                    end
                end
            endcase
            if (start_imm_or_fin) begin
                il = x86d_pkg::imm_len(f_op, f_m);
                if (il != 2'd0) begin
                    phase_next = x86d_pkg::PH_IMM;
                    pend_next = il;
                end else begin
                    emit = 1'b1;
                end
            end
        end
        if (emit) begin
            phase_next = x86d_pkg::PH_OPCODE;
            pend_next = 2'd0;
            pre_next = x86d_pkg::NO_PREFIX;
            len_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= x86d_pkg::PH_OPCODE;
            op_reg    <= 8'd0;
            m_reg     <= 8'd0;
            pend_reg  <= 2'd0;
            disp_reg  <= 16'd0;
            imm_reg   <= 16'd0;
            pre_reg   <= x86d_pkg::NO_PREFIX;
            ip_reg    <= 16'd0;
            len_reg   <= 4'd0;
            raw_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                op_reg    <= op_next;
                m_reg     <= m_next;
                pend_reg  <= pend_next;
                disp_reg  <= disp_next;
                imm_reg   <= imm_next;
                pre_reg   <= pre_next;
                ip_reg    <= ip_next;
                len_reg   <= len_next;
                raw_reg   <= raw_next;
            end
            if (accept) ov_reg <= emit;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit) rec_reg <= rec_next;
    end

    assign out_valid      = ov_reg;
    assign mnemonic       = rec_reg.mnemonic;
    assign operand_word   = rec_reg.operand_word;
    assign mod_field      = rec_reg.mod_field;
    assign reg_field      = rec_reg.reg_field;
    assign rm_field       = rec_reg.rm_field;
    assign to_register    = rec_reg.to_register;
    assign segment_prefix = rec_reg.segment_prefix;
    assign displacement   = rec_reg.displacement;
    assign immediate      = rec_reg.immediate;
    assign branch_target  = rec_reg.branch_target;
    assign instr_length   = rec_reg.instr_length;
    assign unknown        = rec_reg.unknown;
endmodule

// ===== src/x86d_finish.sv =====
// Builds the decoded record of a finished instruction from the held bytes.
module x86d_finish (
    input  logic [7:0]  op,
    input  logic [7:0]  m,
    input  logic [15:0] disp_acc,
    input  logic [15:0] imm_acc,
    input  logic [15:0] ip,
    input  logic [2:0]  prefix,
    input  logic [3:0]  len,
    output x86d_pkg::record_t rec
);
    logic [2:0]  mreg;
    logic [15:0] s8;

    assign mreg = m[5:3];
    assign s8   = x86d_pkg::sext8(imm_acc[7:0]);

    always_comb
    begin
        rec = '0;
        rec.mnemonic       = x86d_pkg::MN_UNKNOWN;
        rec.segment_prefix = prefix;
        rec.instr_length   = len;
        if (x86d_pkg::has_modrm(op)) begin
            rec.mod_field = m[7:6];
            rec.reg_field = mreg;
            rec.rm_field  = m[2:0];
            if (m[7:6] != 2'd3)
                rec.displacement = (x86d_pkg::disp_len(op, m) == 2'd1) ?
                                   x86d_pkg::sext8(disp_acc[7:0]) : disp_acc;
        end
        if (op < 8'h40) begin
            if (op[2:1] != 2'b11) begin
                rec.mnemonic = {4'd0, op[5:3]};
                rec.operand_word = op[0];
                if (!op[2]) rec.to_register = op[1];
                else begin
                    rec.to_register = 1'b1;
                    rec.immediate = imm_acc;
                end
            end else begin
                rec.mnemonic = op[0] ? x86d_pkg::MN_POP_SEG : x86d_pkg::MN_PUSH_SEG;
                rec.operand_word = 1'b1;
                rec.reg_field = {1'b0, op[4:3]};
            end
        end else if (op < 8'h50) begin
            rec.mnemonic = op[3] ? x86d_pkg::MN_DEC : x86d_pkg::MN_INC;
            rec.operand_word = 1'b1;
            rec.reg_field = op[2:0];
        end else if (op < 8'h60) begin
            rec.mnemonic = op[3] ? x86d_pkg::MN_POP : x86d_pkg::MN_PUSH;
            rec.operand_word = 1'b1;
            rec.reg_field = op[2:0];
        end else if (op < 8'h80) begin
            rec.mnemonic = x86d_pkg::MN_JCC + {3'd0, op[3:0]};
            rec.branch_target = ip + s8;
        end else if (op <= 8'h83) begin
            rec.mnemonic = {4'd0, mreg};
            rec.operand_word = (op != 8'h80);
            rec.immediate = (op == 8'h83) ? s8 : imm_acc;
        end else if (op <= 8'h8B) begin
            rec.mnemonic = x86d_pkg::MN_MOV;
            rec.operand_word = op[0];
            rec.to_register = op[1];
        end else if (op == 8'h8C || op == 8'h8E) begin
            rec.mnemonic = x86d_pkg::MN_MOV_SEG;
            rec.operand_word = 1'b1;
            rec.to_register = op[1];
        end else if (op <= 8'hA3) begin
            rec.mnemonic = x86d_pkg::MN_MOV;
            rec.operand_word = op[0];
            rec.to_register = !op[1];
            rec.rm_field = 3'd6;
            rec.displacement = disp_acc;
        end else if (op <= 8'hAF) begin
            rec.mnemonic = x86d_pkg::MN_STRING + {4'd0, op[3:1]} - 7'd2;
            rec.operand_word = op[0];
            rec.immediate = imm_acc;
        end else if (op <= 8'hBF) begin
            rec.mnemonic = x86d_pkg::MN_MOV;
            rec.operand_word = op[3];
            rec.reg_field = op[2:0];
            rec.to_register = 1'b1;
            rec.immediate = imm_acc;
        end else if (op <= 8'hC3) begin
            rec.mnemonic = x86d_pkg::MN_RET;
            rec.immediate = imm_acc;
        end else if (op <= 8'hC5) begin
            rec.mnemonic = (op == 8'hC4) ? x86d_pkg::MN_LES : x86d_pkg::MN_LDS;
            rec.operand_word = 1'b1;
            rec.to_register = 1'b1;
        end else if (op == 8'hC6) begin
            rec.mnemonic = x86d_pkg::MN_MOV;
            rec.immediate = imm_acc;
        end else if (op == 8'hCB) begin
            rec.mnemonic = x86d_pkg::MN_RETF;
        end else if (op == 8'hCD) begin
            rec.mnemonic = x86d_pkg::MN_INT;
            rec.immediate = imm_acc;
        end else if (op <= 8'hD3) begin
            rec.mnemonic = x86d_pkg::shift_mn(mreg);
            rec.operand_word = op[0];
            rec.immediate = {15'd0, !op[1]};
        end else if (op <= 8'hE3) begin
            rec.mnemonic = x86d_pkg::MN_LOOPNZ + {5'd0, op[1:0]};
            rec.branch_target = ip + s8;
        end else if (op <= 8'hE9) begin
            rec.mnemonic = (op == 8'hE8) ? x86d_pkg::MN_CALL : x86d_pkg::MN_JMP;
            rec.branch_target = ip + imm_acc;
        end else if (op == 8'hEB) begin
            rec.mnemonic = x86d_pkg::MN_JMP;
            rec.branch_target = ip + s8;
        end else if (op <= 8'hF3) begin
            rec.mnemonic = x86d_pkg::MN_REPNE + {6'd0, op[0]};
        end else if (op <= 8'hF7) begin
            rec.operand_word = op[0];
            if (mreg == 3'd0) begin
                rec.mnemonic = x86d_pkg::MN_TEST;
                rec.immediate = imm_acc;
            end else begin
                rec.mnemonic = x86d_pkg::MN_GROUP3 + {4'd0, mreg};
            end
        end else if (op <= 8'hFD) begin
            rec.mnemonic = x86d_pkg::MN_FLAGS + {4'd0, op[2:0]};
        end else begin
            rec.mnemonic = x86d_pkg::group5_mn(mreg);
            rec.operand_word = 1'b1;
        end
    end
endmodule

// ===== test/x86_decode_checker.sv =====
// Checker for the x86 decoder: predicts each decoded record and compares it with the output.
`timescale 1ns / 100ps

module x86_decode_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  code_byte,
    input  logic        block_first,
    input  logic [15:0] block_ip,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [6:0]  mnemonic,
    input  logic        operand_word,
    input  logic [1:0]  mod_field,
    input  logic [2:0]  reg_field,
    input  logic [2:0]  rm_field,
    input  logic        to_register,
    input  logic [2:0]  segment_prefix,
    input  logic signed [15:0] displacement,
    input  logic [15:0] immediate,
    input  logic [15:0] branch_target,
    input  logic [3:0]  instr_length,
    input  logic        unknown,
    output int          error_count,
    output int          records_due,
    output int          records_made,
    output int          records_seen
);

    x86d_pkg::record_t expected_records[$];
    x86d_pkg::phase_t  dec_phase;
    logic [7:0]  op_q, modrm_q;
    logic [1:0]  left_q;
    logic [15:0] disp_q, imm_q, ip_q;
    logic [2:0]  seg_q;
    logic [3:0]  len_q;
    logic        raw_q;

    function automatic logic [15:0] sx8(input logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

    function automatic logic takes_modrm(input logic [7:0] op);
        if (op < 8'h40)
            return op[2] == 1'b0;
        return op inside {8'h80, 8'h81, 8'h83, [8'h88:8'h8C], 8'h8E, [8'hC4:8'hC6],
                          [8'hD0:8'hD3], 8'hF6, 8'hF7, 8'hFF};
    endfunction

    function automatic logic is_known(input logic [7:0] op);
        if (op < 8'h40)
            return (op[2:1] != 2'b11) || (op[7:5] == 3'd0 && op[2:1] == 2'b11 && op != 8'h0F);
        if (op < 8'h60 || (op >= 8'h70 && op <= 8'h7F) || takes_modrm(op))
            return 1'b1;
        return op inside {[8'hA0:8'hBF], 8'hC2, 8'hC3, 8'hCB, 8'hCD, [8'hE0:8'hE3], 8'hE8,
                          8'hE9, 8'hEB, 8'hF2, 8'hF3, [8'hF8:8'hFD]};
    endfunction

    function automatic logic second_invalid(input logic [7:0] op, input logic [7:0] m);
        case (op)
            8'h8C, 8'h8E: return m[5];
            8'hC4, 8'hC5: return m[7:6] == 2'b11;
            8'hC6:        return m[5:3] != 3'd0;
            8'hD0, 8'hD1, 8'hD2, 8'hD3: return m[5:3] == 3'd6;
            8'hF6, 8'hF7: return m[5:3] == 3'd1;
            8'hFF:        return m[5:3] == 3'd7 || m[7:3] == 5'b11011 || m[7:3] == 5'b11101;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic logic [1:0] disp_bytes(input logic [7:0] op, input logic [7:0] m);
        if (op >= 8'hA0 && op <= 8'hA3)
            return 2'd2;
        if (!takes_modrm(op))
            return 2'd0;
        case (m[7:6])
            2'd0: return (m[2:0] == 3'd6) ? 2'd2 : 2'd0;
            2'd1: return 2'd1;
            2'd2: return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] imm_bytes(input logic [7:0] op, input logic [7:0] m);
        if (op < 8'h40)
            return (op[2:0] == 3'd4) ? 2'd1 : (op[2:0] == 3'd5) ? 2'd2 : 2'd0;
        if (op inside {[8'h70:8'h7F], 8'h80, 8'h83, 8'hC6, 8'hA8, 8'hCD, 8'hEB,
                       [8'hE0:8'hE3], [8'hB0:8'hB7]})
            return 2'd1;
        if (op inside {8'h81, 8'hA9, 8'hC2, 8'hE8, 8'hE9, [8'hB8:8'hBF]})
            return 2'd2;
        if (op == 8'hF6 || op == 8'hF7)
            return (m[5:3] == 3'd0) ? (op[0] ? 2'd2 : 2'd1) : 2'd0;
        return 2'd0;
    endfunction

    function automatic logic [15:0] place_byte(input logic [15:0] acc, input logic [1:0] n,
                                               input logic [1:0] left, input logic [7:0] b);
        if (n == 2'd2 && left == 2'd2)
            return {acc[15:8], b};
        if (n == 2'd2)
            return {b, acc[7:0]};
        return {8'h00, b};
    endfunction

    function automatic logic [6:0] shift_code(input logic [2:0] r);
        return (r == 3'd6) ? x86d_pkg::MN_UNKNOWN : (r == 3'd7) ? 7'd49 : 7'd43 + 7'(r);
    endfunction

    function automatic logic [6:0] group5_code(input logic [2:0] r);
        case (r)
            3'd0: return x86d_pkg::MN_INC;
            3'd1: return x86d_pkg::MN_DEC;
            3'd2: return x86d_pkg::MN_CALL;
            3'd3: return 7'd56;
            3'd4: return x86d_pkg::MN_JMP;
            3'd5: return 7'd57;
            3'd6: return x86d_pkg::MN_PUSH;
            default: return x86d_pkg::MN_UNKNOWN;
        endcase
    endfunction

    function automatic x86d_pkg::record_t decoded_record();
        logic [7:0]  op;
        logic [7:0]  m;
        logic [2:0]  mreg;
        logic [15:0] s8;
        x86d_pkg::record_t r;
        op = op_q;
        m = modrm_q;
        mreg = m[5:3];
        s8 = sx8(imm_q[7:0]);
        r = '0;
        r.mnemonic = x86d_pkg::MN_UNKNOWN;
        r.segment_prefix = seg_q;
        r.instr_length = len_q;
        if (takes_modrm(op))
        begin
            r.mod_field = m[7:6];
            r.reg_field = mreg;
            r.rm_field = m[2:0];
            if (m[7:6] != 2'd3)
                r.displacement = (disp_bytes(op, m) == 2'd1) ? sx8(disp_q[7:0]) : disp_q;
        end
        if (op < 8'h40)
        begin
            if (op[2:1] != 2'b11)
            begin
                r.mnemonic = {4'd0, op[5:3]};
                r.operand_word = op[0];
                if (!op[2])
                    r.to_register = op[1];
                else
                begin
                    r.to_register = 1'b1;
                    r.immediate = imm_q;
                end
            end
            else
            begin
                r.mnemonic = op[0] ? x86d_pkg::MN_POP_SEG : x86d_pkg::MN_PUSH_SEG;
                r.operand_word = 1'b1;
                r.reg_field = {1'b0, op[4:3]};
            end
        end
        else if (op < 8'h50)
        begin
            r.mnemonic = op[3] ? x86d_pkg::MN_DEC : x86d_pkg::MN_INC;
            r.operand_word = 1'b1;
            r.reg_field = op[2:0];
        end
        else if (op < 8'h60)
        begin
            r.mnemonic = op[3] ? x86d_pkg::MN_POP : x86d_pkg::MN_PUSH;
            r.operand_word = 1'b1;
            r.reg_field = op[2:0];
        end
        else if (op < 8'h80)
        begin
            r.mnemonic = x86d_pkg::MN_JCC + 7'(op[3:0]);
            r.branch_target = ip_q + s8;
        end
        else if (op <= 8'h83)
        begin
            r.mnemonic = {4'd0, mreg};
            r.operand_word = (op != 8'h80);
            r.immediate = (op == 8'h83) ? s8 : imm_q;
        end
        else if (op <= 8'h8B)
        begin
            r.mnemonic = x86d_pkg::MN_MOV;
            r.operand_word = op[0];
            r.to_register = op[1];
        end
        else if (op == 8'h8C || op == 8'h8E)
        begin
            r.mnemonic = x86d_pkg::MN_MOV_SEG;
            r.operand_word = 1'b1;
            r.to_register = op[1];
        end
        else if (op <= 8'hA3)
        begin
            r.mnemonic = x86d_pkg::MN_MOV;
            r.operand_word = op[0];
            r.to_register = !op[1];
            r.rm_field = 3'd6;
            r.displacement = disp_q;
        end
        else if (op <= 8'hAF)
        begin
            r.mnemonic = x86d_pkg::MN_STRING + 7'((op - 8'hA4) >> 1);
            r.operand_word = op[0];
            r.immediate = imm_q;
        end
        else if (op <= 8'hBF)
        begin
            r.mnemonic = x86d_pkg::MN_MOV;
            r.operand_word = op[3];
            r.reg_field = op[2:0];
            r.to_register = 1'b1;
            r.immediate = imm_q;
        end
        else if (op <= 8'hC3)
        begin
            r.mnemonic = x86d_pkg::MN_RET;
            r.immediate = imm_q;
        end
        else if (op <= 8'hC5)
        begin
            r.mnemonic = (op == 8'hC4) ? x86d_pkg::MN_LES : x86d_pkg::MN_LDS;
            r.operand_word = 1'b1;
            r.to_register = 1'b1;
        end
        else if (op == 8'hC6)
        begin
            r.mnemonic = x86d_pkg::MN_MOV;
            r.immediate = imm_q;
        end
        else if (op == 8'hCB)
            r.mnemonic = x86d_pkg::MN_RETF;
        else if (op == 8'hCD)
        begin
            r.mnemonic = x86d_pkg::MN_INT;
            r.immediate = imm_q;
        end
        else if (op <= 8'hD3)
        begin
            r.mnemonic = shift_code(mreg);
            r.operand_word = op[0];
            r.immediate = op[1] ? 16'd0 : 16'd1;
        end
        else if (op <= 8'hE3)
        begin
            r.mnemonic = x86d_pkg::MN_LOOPNZ + 7'(op[1:0]);
            r.branch_target = ip_q + s8;
        end
        else if (op <= 8'hE9)
        begin
            r.mnemonic = (op == 8'hE8) ? x86d_pkg::MN_CALL : x86d_pkg::MN_JMP;
            r.branch_target = ip_q + imm_q;
        end
        else if (op == 8'hEB)
        begin
            r.mnemonic = x86d_pkg::MN_JMP;
            r.branch_target = ip_q + s8;
        end
        else if (op <= 8'hF3)
            r.mnemonic = x86d_pkg::MN_REPNE + 7'(op[0]);
        else if (op <= 8'hF7)
        begin
            r.operand_word = op[0];
            if (mreg == 3'd0)
            begin
                r.mnemonic = x86d_pkg::MN_TEST;
                r.immediate = imm_q;
            end
            else
                r.mnemonic = x86d_pkg::MN_GROUP3 + 7'(mreg);
        end
        else if (op <= 8'hFD)
            r.mnemonic = x86d_pkg::MN_FLAGS + 7'(op - 8'hF8);
        else
        begin
            r.mnemonic = group5_code(mreg);
            r.operand_word = 1'b1;
        end
        return r;
    endfunction

    function automatic x86d_pkg::record_t unknown_record(input logic [15:0] value);
        x86d_pkg::record_t r;
        r = '0;
        r.mnemonic = x86d_pkg::MN_UNKNOWN;
        r.segment_prefix = seg_q;
        r.instr_length = len_q;
        r.immediate = value;
        r.unknown = 1'b1;
        return r;
    endfunction

    task automatic restart_decode();
        dec_phase = x86d_pkg::PH_OPCODE;
        left_q = 2'd0;
        seg_q = x86d_pkg::NO_PREFIX;
        len_q = 4'd0;
    endtask

    task automatic push_record(input x86d_pkg::record_t r);
        expected_records.push_back(r);
        records_made++;
        restart_decode();
    endtask

    task automatic next_stage(input logic disp_done);
        logic [1:0] dl;
        logic [1:0] il;
        dl = disp_bytes(op_q, modrm_q);
        il = imm_bytes(op_q, modrm_q);
        if (!disp_done && dl != 2'd0)
        begin
            dec_phase = x86d_pkg::PH_DISP;
            left_q = dl;
        end
        else if (il != 2'd0)
        begin
            dec_phase = x86d_pkg::PH_IMM;
            left_q = il;
        end
        else
            push_record(decoded_record());
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic first, input logic [15:0] ip);
        x86d_pkg::record_t r;
        if (first)
        begin
            restart_decode();
            raw_q = 1'b0;
            ip_q = ip;
        end
        ip_q = ip_q + 16'd1;
        if (len_q < 4'd15)
            len_q = len_q + 4'd1;
        if (raw_q)
        begin
            r = '0;
            r.mnemonic = x86d_pkg::MN_RAW;
            r.segment_prefix = x86d_pkg::NO_PREFIX;
            r.immediate = {8'h00, b};
            r.instr_length = 4'd1;
            r.unknown = 1'b1;
            push_record(r);
            return;
        end
        case (dec_phase)
            x86d_pkg::PH_MODRM:
            begin
                modrm_q = b;
                if (second_invalid(op_q, b))
                begin
                    raw_q = 1'b1;
                    push_record(unknown_record({b, op_q}));
                end
                else
                    next_stage(1'b0);
            end
            x86d_pkg::PH_DISP:
            begin
                disp_q = place_byte(disp_q, disp_bytes(op_q, modrm_q), left_q, b);
                left_q = left_q - 2'd1;
                if (left_q == 2'd0)
                    next_stage(1'b1);
            end
            x86d_pkg::PH_IMM:
            begin
                imm_q = place_byte(imm_q, imm_bytes(op_q, modrm_q), left_q, b);
                left_q = left_q - 2'd1;
                if (left_q == 2'd0)
                    push_record(decoded_record());
            end
            default:
            begin
                if ((b & 8'hE7) == 8'h26)
                    seg_q = {1'b0, b[4:3]};
                else
                begin
                    op_q = b;
                    modrm_q = 8'h00;
                    disp_q = 16'h0000;
                    imm_q = 16'h0000;
                    if (!is_known(b))
                    begin
                        raw_q = 1'b1;
                        push_record(unknown_record({8'h00, b}));
                    end
                    else if (takes_modrm(b))
                        dec_phase = x86d_pkg::PH_MODRM;
                    else
                        next_stage(1'b0);
                end
            end
        endcase
    endtask

    task automatic check_record();
        x86d_pkg::record_t e;
        if (expected_records.size() == 0)
        begin
            $error("record with nothing expected: mnemonic %0d", mnemonic);
            error_count++;
            return;
        end
        e = expected_records.pop_front();
        records_seen++;
        if (mnemonic != e.mnemonic)
            begin $error("mnemonic: expected %0d, got %0d", e.mnemonic, mnemonic); error_count++; end
        if (operand_word != e.operand_word)
            begin $error("operand_word: expected %0d, got %0d", e.operand_word, operand_word); error_count++; end
        if (mod_field != e.mod_field)
            begin $error("mod_field: expected %0d, got %0d", e.mod_field, mod_field); error_count++; end
        if (reg_field != e.reg_field)
            begin $error("reg_field: expected %0d, got %0d", e.reg_field, reg_field); error_count++; end
        if (rm_field != e.rm_field)
            begin $error("rm_field: expected %0d, got %0d", e.rm_field, rm_field); error_count++; end
        if (to_register != e.to_register)
            begin $error("to_register: expected %0d, got %0d", e.to_register, to_register); error_count++; end
        if (segment_prefix != e.segment_prefix)
            begin $error("segment_prefix: expected %0d, got %0d", e.segment_prefix, segment_prefix); error_count++; end
        if (displacement !== e.displacement)
            begin $error("displacement: expected %h, got %h", e.displacement, displacement); error_count++; end
        if (immediate != e.immediate)
            begin $error("immediate: expected %h, got %h", e.immediate, immediate); error_count++; end
        if (branch_target != e.branch_target)
        begin
            $error("branch_target: expected %h, got %h", e.branch_target, branch_target);
            error_count++;
        end
        if (instr_length != e.instr_length)
            begin $error("instr_length: expected %0d, got %0d", e.instr_length, instr_length); error_count++; end
        if (unknown != e.unknown)
            begin $error("unknown: expected %0d, got %0d", e.unknown, unknown); error_count++; end
    endtask

    initial
    begin
        error_count = 0;
        records_due = 0;
        records_made = 0;
        records_seen = 0;
    end

    // Inputs only change at the rising edge, so the falling edge sees what the next edge takes.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            restart_decode();
            op_q = 8'h00;
            modrm_q = 8'h00;
            disp_q = 16'h0000;
            imm_q = 16'h0000;
            ip_q = 16'h0000;
            raw_q = 1'b0;
            expected_records.delete();
        end
        else
        begin
            if (out_valid === 1'b1 && out_ready === 1'b1)
                check_record();
            if (in_valid === 1'b1 && in_ready === 1'b1)
                decode_byte(code_byte, block_first, block_ip);
        end
        records_due = expected_records.size();
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the x86 decoder: clock, reset, code byte stimulus and verdict.
`timescale 1ns / 100ps

module tb;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  code_byte;
    logic        block_first;
    logic [15:0] block_ip;
    logic        out_valid;
    logic        out_ready;
    logic [6:0]  mnemonic;
    logic        operand_word;
    logic [1:0]  mod_field;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic        to_register;
    logic [2:0]  segment_prefix;
    logic signed [15:0] displacement;
    logic [15:0] immediate;
    logic [15:0] branch_target;
    logic [3:0]  instr_length;
    logic        unknown;

    int error_count;
    int records_due;
    int records_made;
    int records_seen;
    int bytes_sent;
    int blocks_started;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;

    x86_16bit_instruction_decoder dut (.*);

    x86_decode_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(2ms);
        $display("simulation failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off counted here when one is requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic logic legal_opcode(input logic [7:0] op);
        if (op < 8'h40)
            return (op[2:1] != 2'b11) || (op[7:5] == 3'd0 && op != 8'h0F);
        return (op < 8'h60) || op inside {[8'h70:8'h7F], 8'h80, 8'h81, 8'h83, [8'h88:8'h8C],
            8'h8E, [8'hA0:8'hBF], [8'hC2:8'hC6], 8'hCB, 8'hCD, [8'hD0:8'hD3], [8'hE0:8'hE3],
            8'hE8, 8'hE9, 8'hEB, 8'hF2, 8'hF3, 8'hF6, 8'hF7, [8'hF8:8'hFD], 8'hFF};
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] ip);
        logic rdy;
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        code_byte <= b;
        block_first <= first;
        block_ip <= ip;
        do
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end
        while (!rdy);
        bytes_sent++;
        if (first)
            blocks_started++;
    endtask

    task automatic send_list(input logic [7:0] list[], input logic first, input logic [15:0] ip);
        foreach (list[i])
            send_byte(list[i], first && i == 0, ip);
    endtask

    // The sender goes idle first so that the last item is not offered again.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (records_due != 0)
            @(posedge clk);
    endtask

    // One instruction: optional prefix, a legal opcode, then bytes until a record is due.
    // A small share of opcodes and block starts fall anywhere, to break sequences.
    task automatic send_instruction();
        logic [7:0] op;
        logic       first;
        int         made;
        int         tail;
        first = ($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 4) == 0)
        begin
            send_byte(8'h26 | 8'($urandom_range(0, 3) << 3), first, 16'($urandom));
            first = 1'b0;
        end
        op = 8'($urandom);
        if ($urandom_range(0, 19) != 0)
            while (!legal_opcode(op))
                op = 8'($urandom);
        made = records_made;
        send_byte(op, first, ($urandom_range(0, 7) == 0) ? 16'hFFF0 : 16'($urandom));
        tail = 0;
        while (records_made == made && tail < 6)
        begin
            send_byte(8'($urandom), ($urandom_range(0, 99) == 0), 16'($urandom));
            tail++;
        end
    endtask

    initial
    begin
        int phase_no;
        int budget;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        code_byte <= 8'h00;
        block_first <= 1'b0;
        block_ip <= 16'h0000;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        bytes_sent = 0;
        blocks_started = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: word displacement with two prefixes, test immediates, sign-extended
        // immediate, branch wrap, a block start mid-instruction, a bad second byte
        // followed by raw bytes, an unknown opcode and prefix length saturation.
        send_list('{8'h2E, 8'h3E, 8'h8B, 8'h86, 8'h00, 8'h80}, 1'b1, 16'hFFFE);
        send_list('{8'hF6, 8'h00, 8'hFF, 8'hF7, 8'hC0, 8'h34, 8'h12}, 1'b0, 16'h0000);
        send_list('{8'h83, 8'hC0, 8'h80, 8'h75, 8'h7F, 8'hE8, 8'hFF, 8'h7F}, 1'b0, 16'h0000);
        send_list('{8'h81, 8'hC0}, 1'b0, 16'h0000);
        send_list('{8'hD0, 8'hF0, 8'hFF, 8'h00}, 1'b1, 16'hFFFF);
        send_list('{8'h0F, 8'h40}, 1'b1, 16'h1234);
        send_list('{8'h26, 8'h26, 8'h26, 8'h26, 8'h26, 8'h26, 8'h26, 8'h26,
                    8'h26, 8'h26, 8'h26, 8'h26, 8'h26, 8'h2E, 8'h36, 8'h3E, 8'h40},
                  1'b1, 16'h8000);

        for (phase_no = 0; phase_no < 4; phase_no++)
        begin
            send_idle_pct = (phase_no == 1) ? 53 : (phase_no == 3) ? 18 : 0;
            recv_stall_pct = (phase_no == 2) ? 53 : (phase_no == 3) ? 18 : 0;
            if (phase_no == 0)
                hold_request = 80;
            budget = bytes_sent + 250;
            while (bytes_sent < budget)
                send_instruction();
            if (phase_no == 2)
                wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Decoded %0d code bytes in %0d blocks into %0d records,", bytes_sent,
                 blocks_started, records_seen);
        $display("with sender gaps, receiver stalls and a long output hold-off.");
        if (error_count == 0 && records_due == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/x86d_pkg.sv
src/x86d_finish.sv
src/x86_16bit_instruction_decoder.sv
test/x86_decode_checker.sv
test/tb.sv
